// ----- design/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// sts_pkg: shared types and codes for the sorted table search block
// Item layouts for the request and response channels and the function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

   // widths fixed by the item layout
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 8;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 9;

   // function codes of a request item
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EXACT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOWER = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UPPER = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [VALUE_W-1:0] entry_value;
      logic signed [VALUE_W-1:0] target;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/sorted_table_search_top.sv -----
// A write item gives its result in the cycle after acceptance; a search item makes at
// most ceil(log2(table_length + 1)) ram probes, 9 for a full 256-entry table, and an
// empty table answers from the start state without a probe.
// Throughput: one item at a time, one probe per cycle on the table ram's registered
// read port; the next item is taken in the cycle its result leaves.
// Reset: synchronous, clears sequencer, result valid and table_length, not the table.
// ----------------------------------------------------------------------------
// sorted_table_search_top: halving search over a sorted table loaded by write items
// Write items load table entries; search items run exact, lower-bound or
// upper-bound searches with one ram probe per cycle under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_search_top #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire sts_pkg::req_type    req_data,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output sts_pkg::rsp_type         rsp_data,
   // configuration write channel
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [8:0]          csr_table_length
);

   import sts_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;

   // midpoint of [lo, hi); exact mode rounds as the closed-interval form does
   function automatic logic [POS_W-1:0] mid_of(input logic [POS_W-1:0] lo,
                                               input logic [POS_W-1:0] hi,
                                               input logic             bias);
      logic [POS_W:0] sum;
      sum = {1'b0, lo} + {1'b0, hi} - {{POS_W{1'b0}}, bias};
      return sum[POS_W:1];
   endfunction

   logic [1:0]                state_ff, state_in;
   logic [FUNC_W-1:0]         op_ff, op_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [POS_W-1:0]          lo_ff, lo_in;
   logic [POS_W-1:0]          hi_ff, hi_in;
   logic [POS_W-1:0]          mid_ff, mid_in;
   logic [POS_W-1:0]          len_ff, len_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      req_accept;
   logic                      wr_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic signed [VALUE_W-1:0] rd_value;
   logic [POS_W-1:0]          used_len;
   logic                      exact_mode;
   logic                      v_eq, v_lt, go_right;
   logic [POS_W-1:0]          nlo, nhi, nmid;

   // handshakes
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // table length clamped to the table depth
   always_comb begin
      if (32'(len_ff) > 32'(TABLE_DEPTH)) begin
         used_len = POS_W'(TABLE_DEPTH);
      end else begin
         used_len = len_ff;
      end
   end

   // table write, out-of-range indexes dropped
   assign wr_en = req_accept && (req_data.func == FUNC_WRITE) &&
                  (32'(req_data.entry_index) < 32'(TABLE_DEPTH));

   sts_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_data.entry_index)),
      .wr_data (req_data.entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_value)
   );

   // probe compare and next interval
   assign exact_mode = (op_ff == FUNC_EXACT);
   assign v_eq       = (rd_value == key_ff);
   assign v_lt       = (rd_value < key_ff);
   assign go_right   = (op_ff == FUNC_UPPER) ? (v_lt || v_eq) : v_lt;
   assign nlo        = go_right ? (mid_ff + POS_W'(1)) : lo_ff;
   assign nhi        = go_right ? hi_ff : mid_ff;
   assign nmid       = mid_of(nlo, nhi, exact_mode);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_addr      = ADDR_W'(mid_ff);

      if (csr_valid && csr_ready) begin
         len_in = csr_table_length;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in  = req_data.func;
               key_in = req_data.target;
               lo_in  = '0;
               hi_in  = used_len;
               if (req_data.func == FUNC_WRITE) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.found    = 1'b0;
                  rsp_in.position = '0;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            mid_in  = mid_of(lo_ff, hi_ff, exact_mode);
            rd_addr = ADDR_W'(mid_in);
            if (lo_ff < hi_ff) begin
               state_in = ST_PROBE;
            end else begin
               // empty table
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_in.found    = 1'b0;
               rsp_in.position = '0;
            end
         end
         ST_PROBE: begin
            if (exact_mode && v_eq) begin
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_in.found    = 1'b1;
               rsp_in.position = mid_ff;
            end else begin
               lo_in   = nlo;
               hi_in   = nhi;
               mid_in  = nmid;
               rd_addr = ADDR_W'(nmid);
               if (nlo >= nhi) begin
                  state_in        = ST_IDLE;
                  rsp_valid_in    = 1'b1;
                  rsp_in.found    = 1'b0;
                  rsp_in.position = exact_mode ? '0 : nlo;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      rsp_ff <= rsp_in;
   end

   // no result is shown while a search is under way
   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result valid while a search is running");

   // every probe lies inside the live interval
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (lo_ff < hi_ff) && (mid_ff >= lo_ff) && (mid_ff < hi_ff))
      else $error("probe outside the search interval");

   // a search never starts beyond the table length in use
   a_start_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |-> (lo_ff == '0) && (hi_ff <= used_len))
      else $error("search interval starts out of range");

endmodule

`default_nettype wire

// ----- design/sts_ram.sv -----
// ----------------------------------------------------------------------------
// sts_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- dv/sts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_checker: response checker for the sorted table search block
// Watches the request, response and length write channels, keeps its own copy
// of the table and its length, works out the answer to every accepted request
// item and compares each response item with the oldest answer still open.
// ----------------------------------------------------------------------------

module sts_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire sts_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire sts_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [8:0]       csr_table_length,
   output int                    error_count,
   output int                    open_items
);

   import sts_pkg::*;

   localparam int TABLE_DEPTH = 256;

   // shadow of the table and of the length register
   logic signed [VALUE_W-1:0] table_copy [TABLE_DEPTH];
   logic [POS_W-1:0]          length_copy;
   rsp_type                   answer_queue [$];

   // answer to one request item from the current table and length
   function automatic rsp_type predict_answer(input req_type item);
      rsp_type                   answer;
      int                        span;
      int                        lo;
      int                        hi;
      int                        mid;
      logic signed [VALUE_W-1:0] key;
      logic signed [VALUE_W-1:0] probe;
      logic                      go_right;
      answer = '0;
      key    = item.target;
      span   = (length_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_copy);
      case (item.func)
         FUNC_EXACT: begin
            lo = 0;
            hi = span - 1;
            while (lo <= hi && !answer.found) begin
               mid   = lo + (hi - lo) / 2;
               probe = table_copy[mid];
               if (probe == key) begin
                  answer.found    = 1'b1;
                  answer.position = mid[POS_W-1:0];
               end else if (probe < key) begin
                  lo = mid + 1;
               end else begin
                  hi = mid - 1;
               end
            end
         end
         FUNC_LOWER, FUNC_UPPER: begin
            lo = 0;
            hi = span;
            while (lo < hi) begin
               mid      = lo + (hi - lo) / 2;
               probe    = table_copy[mid];
               go_right = (item.func == FUNC_UPPER) ? (probe <= key) : (probe < key);
               if (go_right) begin
                  lo = mid + 1;
               end else begin
                  hi = mid;
               end
            end
            answer.position = lo[POS_W-1:0];
         end
         default: ;
      endcase
      return answer;
   endfunction

   // compare responses, then record new requests and length writes
   always @(posedge clock) begin : watch
      rsp_type expected;
      int      misses;
      misses = 0;
      if (reset) begin
         answer_queue.delete();
         length_copy = '0;
         error_count <= 0;
         open_items  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_queue.size() == 0) begin
               $error("response item with no request open: found %0d position %0d",
                      rsp_data.found, rsp_data.position);
               misses++;
            end else begin
               expected = answer_queue.pop_front();
               if (rsp_data.found !== expected.found) begin
                  $error("found: expected %0d, actual %0d", expected.found, rsp_data.found);
                  misses++;
               end
               if (rsp_data.position !== expected.position) begin
                  $error("position: expected %0d, actual %0d",
                         expected.position, rsp_data.position);
                  misses++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            length_copy = csr_table_length;
         end
         if (req_valid && !req_stall) begin
            answer_queue.push_back(predict_answer(req_data));
            if (req_data.func == FUNC_WRITE) begin
               table_copy[req_data.entry_index] = req_data.entry_value;
            end
         end
         error_count <= error_count + misses;
         open_items  <= answer_queue.size();
      end
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the sorted table search block
// Loads sorted, duplicate-heavy and unsorted tables, sets a range of table
// lengths and runs exact, lower-bound and upper-bound searches under random
// idle and stall patterns; the checker beside the block judges each response.
// ----------------------------------------------------------------------------

module tb;

   import sts_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int ITEM_TARGET  = 1950;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int TABLE_DEPTH  = 256;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_stall;
   req_type          req_data         = '0;
   logic             rsp_valid;
   logic             rsp_stall        = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid        = 1'b0;
   logic             csr_ready;
   logic [POS_W-1:0] csr_table_length = '0;

   int error_count;
   int open_items;
   int items_sent    = 0;
   int send_idle_pct = 19;
   int recv_idle_pct = 88;
   int cycle_count   = 0;
   int table_span    = 0;
   bit hold_request  = 1'b0;

   // values written so far, used to aim search targets
   logic signed [VALUE_W-1:0] loaded_values [TABLE_DEPTH];

   always #2 clock = ~clock;

   sorted_table_search_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_table_length (csr_table_length)
   );

   sts_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_table_length (csr_table_length),
      .error_count      (error_count),
      .open_items       (open_items)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_table_search_top test failed");
         $finish;
      end
   end

   // response side: random stall, plus one long hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // offer one item, with a random idle gap first, and wait until it is taken
   task automatic send_item(input req_type item);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic write_entry(input int index, input logic signed [VALUE_W-1:0] value);
      req_type item;
      item.func        = FUNC_WRITE;
      item.entry_index = index[INDEX_W-1:0];
      item.entry_value = value;
      item.target      = $urandom;
      loaded_values[index] = value;
      send_item(item);
   endtask

   task automatic search(input logic [FUNC_W-1:0] func, input logic signed [VALUE_W-1:0] key);
      req_type item;
      item.func        = func;
      item.entry_index = INDEX_W'($urandom);
      item.entry_value = $urandom;
      item.target      = key;
      send_item(item);
   endtask

   // stop offering and wait until every answer has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_items != 0) @(posedge clock);
   endtask

   task automatic set_length(input int length);
      wait_idle();
      csr_valid        <= 1'b1;
      csr_table_length <= length[POS_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      table_span = (length > TABLE_DEPTH) ? TABLE_DEPTH : length;
   endtask

   // write entries 0 .. count-1, ascending with random strides or scrambled
   task automatic load_entries(input int count, input bit scrambled);
      longint level;
      longint stride;
      int     start;
      int     mode;
      mode  = $urandom_range(0, 2);
      start = $urandom;
      level = ($urandom_range(0, 4) == 0 || mode == 2) ? longint'(VALUE_MIN) : longint'(start);
      case (mode)
         0: stride = 2;
         1: stride = 1000;
         default: stride = (count > 0) ? 64'hffff_ffff / count : 1;
      endcase
      for (int i = 0; i < count; i++) begin
         if (scrambled) begin
            write_entry(i, $urandom);
         end else begin
            write_entry(i, level[VALUE_W-1:0]);
            level += $urandom_range(0, 32'(stride));
            if (level > VALUE_MAX) begin
               level = VALUE_MAX;
            end
         end
      end
   endtask

   initial begin : stimulus
      int                        phase;
      int                        entries;
      int                        length;
      int                        pick;
      int                        slot;
      logic [FUNC_W-1:0]         func_code;
      logic signed [VALUE_W-1:0] key;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table
      search(FUNC_EXACT, 0);
      search(FUNC_LOWER, VALUE_MIN);
      search(FUNC_UPPER, VALUE_MAX);

      // small table with both extremes and runs of duplicates
      write_entry(0, VALUE_MIN);
      write_entry(1, -5);
      write_entry(2, -5);
      write_entry(3, 0);
      write_entry(4, 7);
      write_entry(5, 7);
      write_entry(6, 7);
      write_entry(7, VALUE_MAX);
      set_length(8);
      search(FUNC_EXACT, VALUE_MIN);
      search(FUNC_EXACT, VALUE_MAX);
      search(FUNC_EXACT, 7);
      search(FUNC_EXACT, 3);
      search(FUNC_EXACT, -5);
      search(FUNC_LOWER, 7);
      search(FUNC_UPPER, 7);
      search(FUNC_LOWER, VALUE_MIN);
      search(FUNC_UPPER, VALUE_MAX);
      search(FUNC_LOWER, -6);
      search(FUNC_UPPER, -5);
      search(FUNC_LOWER, VALUE_MAX);

      // random tables, lengths and searches; the first load fills the whole table
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent < ITEM_TARGET / 3) begin
            send_idle_pct = 19;
            recv_idle_pct = 88;
         end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 88;
            recv_idle_pct = 19;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         pick = $urandom_range(0, 99);
         if (phase == 0 || pick < 10) begin
            entries = TABLE_DEPTH;
         end else if (pick < 15) begin
            entries = 0;
         end else begin
            entries = $urandom_range(1, 32);
         end
         load_entries(entries, phase > 0 && $urandom_range(0, 9) == 0);

         // length beyond the table depth, empty and full table among the settings
         pick = $urandom_range(0, 99);
         if (phase == 1) begin
            length = 511;
         end else if (phase > 0 && pick < 6) begin
            length = $urandom_range(TABLE_DEPTH + 1, 511);
         end else if (phase > 0 && pick < 12) begin
            length = 0;
         end else if (pick < 20) begin
            length = TABLE_DEPTH;
         end else begin
            length = entries;
         end
         set_length(length);

         // fill the block while the receiver holds off
         if (phase == 2) begin
            hold_request = 1'b1;
         end

         repeat ($urandom_range(30, 70)) begin
            if ($urandom_range(0, 99) < 5) begin
               write_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
            end else begin
               case ($urandom_range(0, 2))
                  0: func_code = FUNC_EXACT;
                  1: func_code = FUNC_LOWER;
                  default: func_code = FUNC_UPPER;
               endcase
               pick = $urandom_range(0, 99);
               slot = (table_span > 0) ? $urandom_range(0, table_span - 1) : 0;
               if (table_span > 0 && pick < 50) begin
                  key = loaded_values[slot];
               end else if (table_span > 0 && pick < 70) begin
                  key = loaded_values[slot] + ($urandom_range(0, 1) ? 1 : -1);
               end else if (pick < 80) begin
                  key = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
               end else begin
                  key = $urandom;
               end
               search(func_code, key);
            end
         end
         phase++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("sorted_table_search_top test passed");
      end else begin
         $display("sorted_table_search_top test failed");
      end
      $finish;
   end

endmodule
